>>> hw/rtl/zcfm_pkg.sv
// Package for the zero-crossing frequency meter: payload types, register codes and reset values.
package zcfm_pkg;

  localparam int SampleWidth   = 16;
  localparam int PeriodWidth   = 16;
  localparam int CountWidth    = 6;
  localparam int LimitWidth    = 25;
  localparam int DurationWidth = 26;
  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = LimitWidth;

  localparam logic signed [SampleWidth-1:0] ThresholdReset = 16'sd90;
  localparam logic [CountWidth-1:0]         CyclesReset    = 6'd50;
  localparam logic [LimitWidth-1:0]         TimeoutReset   = 25'd20000000;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_CYCLES    = 2'd1,
    CFG_TIMEOUT   = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] voltage_sample;
    logic [PeriodWidth-1:0]        period_ticks;
  } sample_t;

  typedef struct packed {
    logic                     measure_done;
    logic [DurationWidth-1:0] saved_duration;
    logic                     armed;
  } result_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] crossing_threshold;
    logic [CountWidth-1:0]         cycles_per_measure;
    logic [LimitWidth-1:0]         timeout_limit;
  } cfg_t;

endpackage

>>> hw/rtl/zcfm_cfg.sv
// Configuration registers of the zero-crossing frequency meter.
module zcfm_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [zcfm_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [zcfm_pkg::CfgDataWidth-1:0]   cfg_data,
  output zcfm_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crossing_threshold <= zcfm_pkg::ThresholdReset;
      cfg.cycles_per_measure <= zcfm_pkg::CyclesReset;
      cfg.timeout_limit      <= zcfm_pkg::TimeoutReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        zcfm_pkg::CFG_THRESHOLD: begin
          cfg.crossing_threshold <= signed'(cfg_data[zcfm_pkg::SampleWidth-1:0]);
        end
        zcfm_pkg::CFG_CYCLES: begin
          cfg.cycles_per_measure <= cfg_data[zcfm_pkg::CountWidth-1:0];
        end
        zcfm_pkg::CFG_TIMEOUT: begin
          cfg.timeout_limit <= cfg_data[zcfm_pkg::LimitWidth-1:0];
        end
        default: begin
          // unused index: drop the write
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/zcfm_core.sv
// Measurement state and per-item update of the zero-crossing frequency meter.
module zcfm_core (
  input  logic              clk,
  input  logic              rst,
  input  zcfm_pkg::cfg_t    cfg,
  input  logic              accept,
  input  zcfm_pkg::sample_t sample,
  output zcfm_pkg::result_t result
);

  logic                                    armed_flag, armed_flag_next;
  logic [zcfm_pkg::CountWidth-1:0]         cycle_count, cycle_count_next;
  logic [zcfm_pkg::DurationWidth-1:0]      running_duration, running_duration_next;
  logic [zcfm_pkg::DurationWidth-1:0]      last_duration, last_duration_next;
  logic signed [zcfm_pkg::SampleWidth-1:0] previous_sample;

  logic                                    timed_out;
  logic                                    below_before;
  logic                                    done;
  logic [zcfm_pkg::CountWidth-1:0]         count_inc;
  logic [zcfm_pkg::DurationWidth-1:0]      dur_sum;

  always_comb begin
    timed_out    = running_duration > {1'b0, cfg.timeout_limit};
    below_before = previous_sample < cfg.crossing_threshold;
    dur_sum      = running_duration
                 + {{(zcfm_pkg::DurationWidth-zcfm_pkg::PeriodWidth){1'b0}},
                    sample.period_ticks};
    count_inc    = cycle_count + {{(zcfm_pkg::CountWidth-1){1'b0}}, 1'b1};

    done                  = 1'b0;
    armed_flag_next       = armed_flag;
    cycle_count_next      = cycle_count;
    running_duration_next = running_duration;
    last_duration_next    = last_duration;

    if (timed_out) begin
      // abandon the measurement, clear the saved duration and disarm; re-arm on an upward crossing
      last_duration_next    = '0;
      armed_flag_next       = 1'b0;
      cycle_count_next      = '0;
      running_duration_next = '0;
      if (sample.voltage_sample > cfg.crossing_threshold && below_before) begin
        armed_flag_next = 1'b1;
      end
    end else if (armed_flag) begin
      running_duration_next = dur_sum;
      if (sample.voltage_sample >= cfg.crossing_threshold && below_before) begin
        cycle_count_next = count_inc;
        if (count_inc == cfg.cycles_per_measure) begin
          done                  = 1'b1;
          cycle_count_next      = '0;
          last_duration_next    = dur_sum;
          running_duration_next = '0;
        end
      end
    end else begin
      running_duration_next = '0;
      cycle_count_next      = '0;
      if (sample.voltage_sample > cfg.crossing_threshold && below_before) begin
        armed_flag_next = 1'b1;
      end
    end

    result.measure_done   = done;
    result.saved_duration = last_duration_next;
    result.armed          = armed_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_flag       <= 1'b0;
      cycle_count      <= '0;
      running_duration <= '0;
      last_duration    <= '0;
      previous_sample  <= '0;
    end else if (accept) begin
      armed_flag       <= armed_flag_next;
      cycle_count      <= cycle_count_next;
      running_duration <= running_duration_next;
      last_duration    <= last_duration_next;
      previous_sample  <= sample.voltage_sample;
    end
  end

  a_disarmed_idle: assert property (@(posedge clk) disable iff (rst)
    !armed_flag |-> (cycle_count == '0) && (running_duration == '0))
    else $error("disarmed meter holds a nonzero count or duration");

  a_done_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && result.measure_done |=> (cycle_count == '0) && (running_duration == '0))
    else $error("completed measurement did not restart count and duration");

  a_done_saves: assert property (@(posedge clk) disable iff (rst)
    accept && result.measure_done |=> last_duration == $past(result.saved_duration))
    else $error("completed measurement did not save its duration");

  a_timeout_disarms: assert property (@(posedge clk) disable iff (rst)
    accept && timed_out |=> last_duration == '0)
    else $error("timeout did not clear the saved duration");

endmodule

>>> hw/rtl/zcfm_oq.sv
// Two-entry result queue that decouples the sample side from the result side.
module zcfm_oq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  zcfm_pkg::result_t push_data,
  output logic              full,
  output logic              result_valid,
  input  logic              result_stall,
  output zcfm_pkg::result_t result
);

  logic [1:0]        count, count_next;
  zcfm_pkg::result_t head, tail;
  logic              pop;

  assign pop          = result_valid && !result_stall;
  assign result_valid = count != 2'd0;
  assign full         = count == 2'd2;
  assign result       = head;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        head <= tail;
      end else if (push) begin
        head <= push_data;
      end
    end else if (push && count == 2'd0) begin
      head <= push_data;
    end
    if (push && !pop && count == 2'd1) begin
      tail <= push_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("item pushed into a full result queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("result queue count did not advance on push");

  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    push && count == 2'd0 |=> result == $past(push_data))
    else $error("result queue lost an item written while empty");

endmodule

>>> hw/rtl/zero_crossing_frequency_meter.sv
// Top level of the zero-crossing frequency meter.
//
// Usage:
//   Sample channel: sample_valid / sample_stall / sample carry one voltage
//   sample and the timer ticks since the previous sample. An item is taken
//   at a clock edge with sample_valid high and sample_stall low.
//   Result channel: result_valid / result_stall / result carry one result
//   item per sample: done pulse, saved duration and armed flag.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 threshold, 1 cycles per measurement, 2 timeout); other indexes are
//   ignored. Write only while no result is outstanding.
// Throughput:
//   One sample per cycle while sample_stall is low. The measurement state
//   updates as the sample is taken; its result is queued behind older ones.
//   The per-sample compare/add/compare path is the only logic between the
//   state registers and the two-entry result queue.
// Reset (rst, synchronous): configuration returns to threshold 90,
//   50 crossings per measurement, timeout 20000000; the meter disarms,
//   clears count, duration and saved duration; the result queue empties.
// Stall: the result queue holds two items; sample_stall rises only when
//   both are waiting, so a stalled receiver backs up the sample side.
module zero_crossing_frequency_meter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  zcfm_pkg::sample_t                   sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output zcfm_pkg::result_t                   result,
  input  logic                                cfg_we,
  input  logic [zcfm_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [zcfm_pkg::CfgDataWidth-1:0]   cfg_data
);

  zcfm_pkg::cfg_t    cfg;
  zcfm_pkg::result_t core_result;
  logic              accept;
  logic              queue_full;

  // take a sample whenever the result queue has room
  assign sample_stall = queue_full;
  assign accept       = sample_valid && !queue_full;

  zcfm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // advance the measurement state once per accepted sample
  zcfm_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .sample (sample),
    .result (core_result)
  );

  // hold results until the receiver takes them
  zcfm_oq u_oq (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .push_data    (core_result),
    .full         (queue_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
